>>> sv/sqerr_pkg.sv
// ----------------------------------------------------------------------------
// sqerr_pkg
// Shared types, constants and label normalization tables for the
// scaled-label squared error loss block.
// ----------------------------------------------------------------------------
package sqerr_pkg;

  localparam int CHANNELS = 14;
  localparam int CH_W     = 4;
  localparam int DATA_W   = 24;
  localparam int INV_W    = 17;
  localparam int LOSS_W   = 32;
  localparam int SUM_W    = 48;

  // configuration register indexes
  localparam logic CFG_INV_BATCH   = 1'b0;
  localparam logic CFG_LOSS_WEIGHT = 1'b1;

  typedef logic signed [DATA_W-1:0] q816_t;

  // one normalized element, front to back
  typedef struct packed {
    logic  last;
    q816_t diff;
  } q_entry_t;

  // configuration registers
  typedef struct packed {
    logic [INV_W-1:0] inv_batch;
    q816_t            loss_weight;
  } cfg_t;

  // per-channel label scale, unsigned Q.24
  function automatic logic [23:0] norm_scale(input logic [CH_W-1:0] ch);
    logic [23:0] s;
    case (ch)
      4'd0:    s = 24'd15252015;
      4'd1:    s = 24'd2982653;
      4'd2:    s = 24'd2440246;
      4'd3:    s = 24'd2982653;
      4'd4:    s = 24'd176602;
      4'd5:    s = 24'd176602;
      4'd6:    s = 24'd2440246;
      4'd7:    s = 24'd2684355;
      4'd8:    s = 24'd2684355;
      4'd9:    s = 24'd2440246;
      4'd10:   s = 24'd176602;
      4'd11:   s = 24'd176602;
      4'd12:   s = 24'd176602;
      4'd13:   s = 24'd10066330;
      default: s = 24'd15252015;
    endcase
    return s;
  endfunction

  // per-channel label offset, signed Q.16
  function automatic logic signed [17:0] norm_offset(input logic [CH_W-1:0] ch);
    logic signed [17:0] o;
    case (ch)
      4'd0:    o = 18'sd32768;
      4'd1:    o = 18'sd88110;
      4'd2:    o = 18'sd25619;
      4'd3:    o = -18'sd22574;
      4'd4:    o = 18'sd7864;
      4'd5:    o = 18'sd7864;
      4'd6:    o = 18'sd97112;
      4'd7:    o = 18'sd64225;
      4'd8:    o = 18'sd1311;
      4'd9:    o = -18'sd31576;
      4'd10:   o = 18'sd7864;
      4'd11:   o = 18'sd7864;
      4'd12:   o = 18'sd7864;
      4'd13:   o = 18'sd13107;
      default: o = 18'sd32768;
    endcase
    return o;
  endfunction

endpackage

>>> sv/sqerr_front.sv
// ----------------------------------------------------------------------------
// sqerr_front
// Accepts elements, tracks the channel, normalizes the label and forms the
// saturated difference, then pushes it into the queue.
// ----------------------------------------------------------------------------
module sqerr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sqerr_pkg::q816_t    prediction,
  input  sqerr_pkg::q816_t    label,
  input  logic                last,
  output logic                push,
  output sqerr_pkg::q_entry_t push_data,
  input  logic                full
);
  import sqerr_pkg::*;

  logic              accept;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic              stg_valid_r, stg_valid_nxt;
  logic signed [48:0] prod_r;
  q816_t             pred_r;
  logic              last_r;
  logic [CH_W-1:0]   stg_chan_r;

  logic signed [24:0] scale_s;
  logic signed [48:0] prod_w;
  logic signed [48:0] prod_rnd;
  logic signed [24:0] y_lab;
  logic signed [17:0] off_s;
  logic signed [25:0] y_off;
  logic signed [25:0] y_cl;
  logic signed [26:0] dw;
  q816_t             diff_w;

  assign accept   = in_valid && in_ready;
  assign in_ready = !stg_valid_r || !full;
  assign push     = stg_valid_r && !full;

  // stage 1: label times channel scale
  assign scale_s = $signed({1'b0, norm_scale(ch_r)});
  assign prod_w  = label * scale_s;

  // stage 2: round, offset, clamp channel 0, subtract; stage 2 runs on the
  // channel captured with the element, the live counter has moved on
  assign prod_rnd = prod_r + 49'sd8388608;
  assign y_lab    = prod_rnd[48:24];
  assign off_s    = norm_offset(stg_chan_r);
  assign y_off    = {y_lab[24], y_lab} + {{8{off_s[17]}}, off_s};

  always_comb begin
    y_cl = y_off;
    if (stg_chan_r == '0) begin
      if (y_off > 26'sd65536) y_cl = 26'sd65536;
      else if (y_off < 26'sd0) y_cl = 26'sd0;
    end
  end

  assign dw = {{3{pred_r[23]}}, pred_r} - {y_cl[25], y_cl};

  always_comb begin
    if (dw > 27'sd8388607)       diff_w = 24'sh7FFFFF;
    else if (dw < -27'sd8388608) diff_w = 24'sh800000;
    else                         diff_w = dw[23:0];
  end

  assign push_data.last = last_r;
  assign push_data.diff = diff_w;

  always_comb begin
    ch_nxt = ch_r;
    if (accept) begin
      if (last || ch_r == CH_W'(CHANNELS - 1)) ch_nxt = '0;
      else                                     ch_nxt = ch_r + 1'b1;
    end
  end

  assign stg_valid_nxt = accept || (stg_valid_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r     <= prod_w;
      pred_r     <= prediction;
      last_r     <= last;
      stg_chan_r <= ch_r;
    end
  end

  // channel counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
    end else begin
      ch_r <= ch_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) (accept && last) |=> (ch_r == '0))
    else $error("channel index not cleared after batch end");
  assert property (@(posedge clk) disable iff (!rst_n) ch_r < CH_W'(CHANNELS))
    else $error("channel index out of range");
  assert property (@(posedge clk) disable iff (!rst_n) (stg_valid_r && full) |-> !in_ready)
    else $error("request taken while stage is blocked");

endmodule

>>> sv/sqerr_queue.sv
// ----------------------------------------------------------------------------
// sqerr_queue
// Short FIFO of normalized differences between front and back.
// ----------------------------------------------------------------------------
module sqerr_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sqerr_pkg::q_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                pop_valid,
  output sqerr_pkg::q_entry_t pop_data
);
  import sqerr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign do_pop    = pop && pop_valid;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");

endmodule

>>> sv/sqerr_back.sv
// ----------------------------------------------------------------------------
// sqerr_back
// Sequencer that forms gradient, accumulates squares, computes the batch
// loss and holds the result in an output register.
// ----------------------------------------------------------------------------
module sqerr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sqerr_pkg::cfg_t     cfg,
  input  logic                q_valid,
  input  sqerr_pkg::q_entry_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sqerr_pkg::q816_t    out_difference,
  output sqerr_pkg::q816_t    out_gradient,
  output logic                out_loss_valid,
  output logic [sqerr_pkg::LOSS_W-1:0] out_loss
);
  import sqerr_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TPROD = 9'b000000010,
    S_GRAD  = 9'b000000100,
    S_SQ    = 9'b000001000,
    S_ACC   = 9'b000010000,
    S_LLO   = 9'b000100000,
    S_LHI   = 9'b001000000,
    S_LSUM  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  q816_t             diff_r;
  logic              last_r;
  logic signed [25:0] t_r;
  q816_t             grad_r;
  logic [SUM_W-1:0]  sq_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [40:0]       lo_r, hi_r;
  logic [LOSS_W-1:0] loss_r;
  logic              load;

  logic              ov_r, ov_nxt;
  q816_t             od_r, og_r;
  logic              olv_r;
  logic [LOSS_W-1:0] ol_r;

  logic signed [17:0] inv_s;
  logic signed [41:0] p1, p1_rnd;
  logic signed [49:0] p2, p2_rnd;
  logic signed [33:0] g_w;
  q816_t             g_sat;
  logic signed [47:0] sq_w;
  logic [SUM_W:0]    acc_w;
  logic [40:0]       lo_w, hi_w;
  logic [64:0]       tot_w;
  logic [32:0]       r_inc;

  assign inv_s  = $signed({1'b0, cfg.inv_batch});
  assign p1     = diff_r * inv_s;
  assign p1_rnd = p1 + 42'sd32768;

  assign p2     = t_r * cfg.loss_weight;
  assign p2_rnd = p2 + 50'sd32768;
  assign g_w    = p2_rnd[49:16];

  always_comb begin
    if (g_w > 34'sd8388607)       g_sat = 24'sh7FFFFF;
    else if (g_w < -34'sd8388608) g_sat = 24'sh800000;
    else                          g_sat = g_w[23:0];
  end

  assign sq_w  = diff_r * diff_r;
  assign acc_w = {1'b0, sum_r} + {1'b0, sq_r};

  // sum * inv_batch in two 24-bit halves; the product wraps at 64 bits
  assign lo_w  = sum_r[23:0]  * cfg.inv_batch;
  assign hi_w  = sum_r[47:24] * cfg.inv_batch;
  assign tot_w = {hi_r, 24'b0} + {24'b0, lo_r};
  assign r_inc = {1'b0, tot_w[63:32]} + 33'd1;

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign load  = (state_r == S_OUT) && (!ov_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_TPROD;
      S_TPROD: state_nxt = S_GRAD;
      S_GRAD:  state_nxt = S_SQ;
      S_SQ:    state_nxt = S_ACC;
      S_ACC: begin
        sum_nxt   = acc_w[SUM_W] ? {SUM_W{1'b1}} : acc_w[SUM_W-1:0];
        state_nxt = last_r ? S_LLO : S_OUT;
      end
      S_LLO:   state_nxt = S_LHI;
      S_LHI:   state_nxt = S_LSUM;
      S_LSUM: begin
        sum_nxt   = '0;
        state_nxt = S_OUT;
      end
      S_OUT:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ov_nxt = load || (ov_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      diff_r <= q_data.diff;
      last_r <= q_data.last;
    end
    if (state_r == S_TPROD) t_r    <= p1_rnd[41:16];
    if (state_r == S_GRAD)  grad_r <= g_sat;
    if (state_r == S_SQ)    sq_r   <= sq_w[SUM_W-1:0];
    if (state_r == S_LLO)   lo_r   <= lo_w;
    if (state_r == S_LHI)   hi_r   <= hi_w;
    if (state_r == S_LSUM)  loss_r <= r_inc[32:1];
    if (load) begin
      od_r  <= diff_r;
      og_r  <= grad_r;
      olv_r <= last_r;
      ol_r  <= last_r ? loss_r : '0;
    end
  end

  assign out_valid      = ov_r;
  assign out_difference = od_r;
  assign out_gradient   = og_r;
  assign out_loss_valid = olv_r;
  assign out_loss       = ol_r;

  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_LSUM) |=> (sum_r == '0))
    else $error("square sum not cleared at batch end");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_ACC) |=> (sum_r >= $past(sum_r)))
    else $error("square sum decreased on accumulate");
  assert property (@(posedge clk) disable iff (!rst_n) (ov_r && !olv_r) |-> (ol_r == '0))
    else $error("loss field nonzero without loss flag");

endmodule

>>> sv/scaled_label_squared_error_loss.sv
// ----------------------------------------------------------------------------
// scaled_label_squared_error_loss
// Streaming Euclidean loss with per-channel label normalization: emits the
// difference and gradient per element and the batch loss on the last one.
// ----------------------------------------------------------------------------
//  port group | dir | moves                     | payload
//  -----------+-----+---------------------------+------------------------------
//  in_*       | in  | one element request       | prediction, label; tlast=last
//  out_*      | out | one result request        | difference, gradient, loss;
//             |     |                           | tuser=loss_valid
//  cfg_*      | in  | register write, no ack    | 0: inv_batch, 1: loss_weight
//
//  Front: an accepted element is multiplied into the stage register, then normalized and queued.
//  Back: the sequencer steps one multiply per state (gradient, square, loss
//  halves) and takes the next element only once OUT has loaded the result.
//  Reset (rst_n low, synchronous) clears control, channel index and the sum.
//  The queue of QUEUE_DEPTH entries keeps the input side taking requests
//  while the back end waits on out_tready, until the queue is full.
// ----------------------------------------------------------------------------
module scaled_label_squared_error_loss #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [23:0] prediction, [47:24] label
  input  logic        in_tlast,   // last element of the batch
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [23:0] difference, [47:24] gradient, [79:48] loss
  output logic        out_tuser,  // [0] loss_valid
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);
  import sqerr_pkg::*;

  cfg_t              cfg_r;
  q_entry_t          push_data, pop_data;
  logic              push, full, pop, pop_valid;
  q816_t             o_diff, o_grad;
  logic [LOSS_W-1:0] o_loss;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_batch   <= 17'h10000;
      cfg_r.loss_weight <= 24'sh010000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_BATCH:   cfg_r.inv_batch   <= cfg_wdata[INV_W-1:0];
        CFG_LOSS_WEIGHT: cfg_r.loss_weight <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sqerr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .prediction (in_tdata[23:0]),
    .label      (in_tdata[47:24]),
    .last       (in_tlast),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  sqerr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  sqerr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (pop_valid),
    .q_data         (pop_data),
    .q_pop          (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_difference (o_diff),
    .out_gradient   (o_grad),
    .out_loss_valid (out_tuser),
    .out_loss       (o_loss)
  );

  assign out_tdata = {o_loss, o_grad, o_diff};

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scaled-label squared error loss block. A
// scoreboard predicts every result (difference, gradient, batch loss) from
// each accepted element request and compares it with the output stream.
// Runs a directed set, then random phases under several register settings,
// with random idling on both streams and one long back-pressure hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import sqerr_pkg::*;

  localparam q816_t Q816_MAX = 24'sh7FFFFF;
  localparam q816_t Q816_MIN = 24'sh800000;

  localparam int PHASES         = 8;
  localparam int PHASE_ELEMS    = 156;   // ~1250 random elements overall
  localparam int HOLDOFF_CYCLES = 300;   // long receiver stall, fills the queue
  localparam int DRAIN_CYCLES   = 24;    // covers the front stage and the back-end sequence, with margin

  // expected content of one result request
  typedef struct {
    q816_t       diff;
    q816_t       grad;
    logic        loss_valid;
    logic [31:0] loss;
  } loss_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers, the square sum and the channel.
  // --------------------------------------------------------------------------
  class loss_scoreboard;
    logic [INV_W-1:0]  inv_batch;
    q816_t             loss_weight;
    longint unsigned   square_sum;
    int unsigned       chan;
    loss_result_t      pending_results[$];
    int unsigned       mismatches;

    function new();
      inv_batch   = 17'd65536;
      loss_weight = 24'sd65536;
      square_sum  = 0;
      chan        = 0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic idx, logic [23:0] value);
      if (idx == CFG_INV_BATCH) inv_batch = value[INV_W-1:0];
      else                      loss_weight = value;
    endfunction

    // label scale per channel, Q.24
    function longint label_scale(int unsigned ch);
      case (ch)
        0:           return 15252015;
        1, 3:        return 2982653;
        2, 6, 9:     return 2440246;
        7, 8:        return 2684355;
        13:          return 10066330;
        default:     return 176602;    // 4, 5, 10, 11, 12
      endcase
    endfunction

    // label offset per channel, Q.16
    function longint label_offset(int unsigned ch);
      case (ch)
        0:           return 32768;
        1:           return 88110;
        2:           return 25619;
        3:           return -22574;
        6:           return 97112;
        7:           return 64225;
        8:           return 1311;
        9:           return -31576;
        13:          return 13107;
        default:     return 7864;      // 4, 5, 10, 11, 12
      endcase
    endfunction

    // round half up, then drop sh fraction bits
    function longint round_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function longint clip24(longint v);
      if (v > longint'(Q816_MAX)) return longint'(Q816_MAX);
      if (v < longint'(Q816_MIN)) return longint'(Q816_MIN);
      return v;
    endfunction

    // predict the result of one accepted element request
    function void note_request(q816_t pred, q816_t lab, logic last);
      longint          y, diff, t, grad, ib, lw;
      longint unsigned sq, prod, loss;
      loss_result_t    r;
      y = round_shift(longint'(lab) * label_scale(chan), 24) + label_offset(chan);
      if (chan == 0) begin
        // channel 0 label is a probability: clamp to [0, 1]
        if (y > 65536) y = 65536;
        if (y < 0) y = 0;
      end
      diff = clip24(longint'(pred) - y);
      ib   = longint'(inv_batch);
      lw   = longint'(loss_weight);
      t    = round_shift(diff * ib, 16);
      grad = clip24(round_shift(t * lw, 16));
      sq   = longint'(diff * diff);
      square_sum = square_sum + sq;
      if (square_sum > 64'hFFFF_FFFF_FFFF) square_sum = 64'hFFFF_FFFF_FFFF;
      r.diff = q816_t'(diff);
      r.grad = q816_t'(grad);
      if (last) begin
        // 64-bit product, wraps for inv_batch above one and a huge sum
        prod = square_sum * longint'(inv_batch);
        loss = ((prod >> 32) + 1) >> 1;
        if (loss > 64'hFFFF_FFFF) loss = 64'hFFFF_FFFF;
        r.loss_valid = 1'b1;
        r.loss       = loss[31:0];
        square_sum   = 0;
        chan         = 0;
      end else begin
        r.loss_valid = 1'b0;
        r.loss       = '0;
        chan         = (chan + 1 >= CHANNELS) ? 0 : chan + 1;
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [79:0] data, logic tag);
      loss_result_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: diff %0d grad %0d valid %b loss %0d",
                   $realtime, $signed(data[23:0]), $signed(data[47:24]), tag, data[79:48]);
        return;
      end
      e = pending_results.pop_front();
      if (data[23:0] !== e.diff || data[47:24] !== e.grad ||
          tag !== e.loss_valid || data[79:48] !== e.loss) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp diff %0d grad %0d valid %b loss %0d",
                   $realtime, e.diff, e.grad, e.loss_valid, e.loss);
          $display("%0t:          got diff %0d grad %0d valid %b loss %0d",
                   $realtime, $signed(data[23:0]), $signed(data[47:24]), tag, data[79:48]);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [23:0] prediction, [47:24] label
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // [23:0] difference, [47:24] gradient, [79:48] loss
  logic        out_tuser;  // [0] loss_valid
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_wdata;

  loss_scoreboard sb;
  bit src_idle_en;     // sender inserts gaps
  bit snk_idle_en;     // receiver inserts stalls
  bit holdoff_req;     // one long receiver stall

  scaled_label_squared_error_loss DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard limit on the run, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stall bursts, plus the long hold-off when requested
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
      sb.check_result(out_tdata, out_tuser);
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // one element request; optional random gap before it
  task automatic send_elem(input q816_t pred, input q816_t lab, input logic last);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {lab, pred};
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(pred, lab, last);
  endtask

  // write both registers, only while idle; junk in the unused inv_batch bits
  task automatic set_config(input logic [INV_W-1:0] inv, input logic [23:0] lw);
    logic [23:0] inv_word;
    inv_word = {7'($urandom()), inv};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INV_BATCH;
    cfg_wdata <= inv_word;
    @(posedge clk);
    sb.write_reg(CFG_INV_BATCH, inv_word);
    cfg_index <= CFG_LOSS_WEIGHT;
    cfg_wdata <= lw;
    @(posedge clk);
    sb.write_reg(CFG_LOSS_WEIGHT, lw);
    cfg_we <= 1'b0;
  endtask

  // stop offering and let the block go idle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic q816_t rand_q816();
    q816_t v;
    case ($urandom_range(0, 7))
      0:       v = Q816_MAX;
      1:       v = Q816_MIN;
      2, 3: begin
        v = 24'($urandom_range(0, 262143));
        v = v - 24'sd131072;            // within +-2.0, the usual label range
      end
      default: v = 24'($urandom());
    endcase
    return v;
  endfunction

  // random batches: mostly whole samples ending in last, some broken runs
  task automatic run_random(input int n_elems);
    int sent;
    int len;
    int kind;
    bit close_batch;
    sent = 0;
    while (sent < n_elems) begin
      kind = $urandom_range(0, 9);
      close_batch = 1'b1;
      if (kind < 7) begin
        len = CHANNELS * $urandom_range(1, 3);
      end else if (kind == 7) begin
        len = $urandom_range(1, 40);      // last at an odd channel
      end else if (kind == 8) begin
        len = $urandom_range(1, 40);      // no last, runs into the next batch
        close_batch = 1'b0;
      end else begin
        len = 1;
      end
      for (int i = 0; i < len; i++)
        send_elem(rand_q816(), rand_q816(), close_batch && (i == len - 1));
      sent += len;
    end
  endtask

  // directed: clamp, saturation, channel wrap, sum saturation, short batches
  task automatic run_directed();
    send_elem(24'sd0, Q816_MAX, 1'b0);      // ch0 label clamps to 1.0
    send_elem(Q816_MAX, Q816_MIN, 1'b0);    // difference saturates high
    send_elem(Q816_MIN, Q816_MAX, 1'b0);    // difference saturates low
    send_elem(24'sd0, 24'sd0, 1'b0);
    for (int ch = 4; ch < CHANNELS; ch++)
      send_elem(rand_q816(), rand_q816(), 1'b0);
    // channel wraps to 0; large squares drive the sum into saturation
    send_elem(Q816_MAX, Q816_MIN, 1'b0);    // ch0 label clamps to 0
    send_elem(Q816_MAX, Q816_MIN, 1'b0);
    send_elem(Q816_MIN, Q816_MAX, 1'b0);
    send_elem(Q816_MAX, Q816_MIN, 1'b0);
    send_elem(Q816_MIN, Q816_MAX, 1'b1);    // loss of a saturated sum
    send_elem(24'sd65536, Q816_MAX, 1'b1);  // single element batch, zero diff
    send_elem(-24'sd1, -24'sd1, 1'b1);
    send_elem(24'sd1, 24'sd1, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [INV_W-1:0] inv_set[PHASES];
    logic [23:0]      lw_set[PHASES];

    sb = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_INV_BATCH;
    cfg_wdata   <= '0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    holdoff_req = 1'b0;

    // register settings per phase: unity, the extremes, out-of-range inv_batch
    inv_set = '{17'd65536, 17'd1, 17'd65536, 17'd0,
                17'd131071, 17'($urandom_range(1, 65536)), 17'd4681, 17'd32768};
    lw_set  = '{24'd65536, 24'h800000, 24'h7FFFFF, 24'($urandom()),
                24'($urandom()), 24'($urandom()), 24'hFF0000, 24'd65536};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset values, written explicitly
    set_config(17'd65536, 24'd65536);
    run_directed();
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_config(inv_set[p], lw_set[p]);
      // phase 2: receiver holds off while the sender streams without gaps
      if (p == 2) begin
        src_idle_en = 1'b0;
        holdoff_req = 1'b1;
      end else begin
        src_idle_en = (p != PHASES - 1);
      end
      snk_idle_en = (p != PHASES - 1);
      run_random(PHASE_ELEMS);
      drain();
      // a phase may start mid-batch, since run_random can end on a run without
      // last; the scoreboard tracks the channel as the block does, nothing to do here
    end

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
